/* hdl/ijs_pkg.sv */
package ijs_pkg;

	localparam int unsigned MAX_JOINTS = 8;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned CFG_W      = 4;
	localparam int unsigned OUT_IDX_W  = 3;
	localparam int unsigned SLOT_W     = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int unsigned CNT_W      = $clog2(MAX_JOINTS + 1);
	localparam int unsigned DIV_CNT_W  = $clog2(DATA_W);

	localparam logic [CFG_W-1:0]  JOINT_COUNT_RST = CFG_W'(3);
	localparam logic [DATA_W-1:0] SAT_VAL         = {DATA_W{1'b1}};

	typedef logic [DATA_W-1:0] word_t;

endpackage

/* hdl/ijs_div.sv */
module ijs_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ijs_pkg::word_t num,
	input  ijs_pkg::word_t den,
	output logic           done,
	output ijs_pkg::word_t quo
);

	logic                                   busy_q;
	logic                                   done_q;
	logic [ijs_pkg::DIV_CNT_W-1:0]          cnt_q;
	logic [ijs_pkg::DATA_W-1:0]             rem_q;
	logic [ijs_pkg::DATA_W-1:0]             den_q;
	logic [ijs_pkg::DATA_W-1:0]             nsh_q;
	logic [ijs_pkg::DATA_W-1:0]             quo_q;
	logic [ijs_pkg::DATA_W:0]               trial;
	logic                                   qbit;
	logic [ijs_pkg::DATA_W:0]               diff;
	logic                                   sat;

	// quotient overflows 32 bits exactly when num >> 16 >= den
	assign sat   = {{ijs_pkg::FRAC_W{1'b0}}, num[ijs_pkg::DATA_W-1:ijs_pkg::FRAC_W]} >= den;
	assign trial = {rem_q, nsh_q[ijs_pkg::DATA_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = !diff[ijs_pkg::DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= ijs_pkg::DIV_CNT_W'(ijs_pkg::DATA_W - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= ijs_pkg::SAT_VAL;
			den_q <= den;
			rem_q <= {{ijs_pkg::FRAC_W{1'b0}}, num[ijs_pkg::DATA_W-1:ijs_pkg::FRAC_W]};
			nsh_q <= {num[ijs_pkg::FRAC_W-1:0], {(ijs_pkg::DATA_W-ijs_pkg::FRAC_W){1'b0}}};
		end else if (busy_q) begin
			quo_q <= {quo_q[ijs_pkg::DATA_W-2:0], qbit};
			nsh_q <= {nsh_q[ijs_pkg::DATA_W-2:0], 1'b0};
			if (qbit) begin
				rem_q <= diff[ijs_pkg::DATA_W-1:0];
			end else begin
				rem_q <= trial[ijs_pkg::DATA_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* hdl/isochronous_joint_speeds_top.sv */
// Synchronized joint velocity scaling. Each input beat loads one joint (current
// position, target position, reference speed, Q16.16); after joint_count joints
// the block emits one velocity beat per joint, distance / largest travel time,
// with last on the final one. A single shared restoring divider resolves one
// quotient bit per cycle; a joint with zero distance, or any joint of a set
// with a speed error, skips the velocity divide. One joint is handled at a
// time; in_stall stays high while the divider or the emit sequence is busy.
module isochronous_joint_speeds_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [31:0]              current_position,
	input  logic signed [31:0]              target_position,
	input  logic signed [31:0]              reference_speed,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ijs_pkg::OUT_IDX_W-1:0]   joint_index,
	output logic [31:0]                     joint_velocity,
	output logic                            speed_error,
	output logic                            last
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TIME = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_VEL  = 3'd3;
	localparam logic [2:0] S_VDIV = 3'd4;
	localparam logic [2:0] S_PUT  = 3'd5;

	logic [2:0]                     state_q;
	logic [ijs_pkg::CFG_W-1:0]      joint_count_q;
	ijs_pkg::word_t                 dist_q [ijs_pkg::MAX_JOINTS];
	ijs_pkg::word_t                 largest_q;
	logic [ijs_pkg::CNT_W-1:0]      loaded_q;
	logic                           err_q;
	logic [ijs_pkg::SLOT_W-1:0]     k_q;
	ijs_pkg::word_t                 vel_q;

	logic                           out_valid_q;
	logic [ijs_pkg::OUT_IDX_W-1:0]  idx_out_q;
	ijs_pkg::word_t                 vel_out_q;
	logic                           err_out_q;
	logic                           last_out_q;

	logic                           in_acc;
	logic                           cfg_wr;
	logic [32:0]                    diff;
	ijs_pkg::word_t                 span;
	logic                           spd_ok;
	logic [ijs_pkg::SLOT_W-1:0]     slot;
	logic [ijs_pkg::CNT_W-1:0]      n_eff;
	ijs_pkg::word_t                 d_k;
	logic                           out_free;
	logic                           k_last;

	logic                           div_start;
	ijs_pkg::word_t                 div_num;
	ijs_pkg::word_t                 div_den;
	logic                           div_done;
	ijs_pkg::word_t                 div_quo;

	ijs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {{(32-ijs_pkg::CFG_W){1'b0}}, joint_count_q} : '0;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign diff   = {target_position[31], target_position} - {current_position[31], current_position};
	assign span   = diff[32] ? 32'(-diff) : diff[31:0];
	assign spd_ok = !reference_speed[31] && (reference_speed != '0);

	always_comb begin
		if (loaded_q >= ijs_pkg::CNT_W'(ijs_pkg::MAX_JOINTS)) begin
			slot = ijs_pkg::SLOT_W'(ijs_pkg::MAX_JOINTS - 1);
		end else begin
			slot = loaded_q[ijs_pkg::SLOT_W-1:0];
		end
		if (joint_count_q == '0) begin
			n_eff = ijs_pkg::CNT_W'(1);
		end else if ({1'b0, joint_count_q} > 5'(ijs_pkg::MAX_JOINTS)) begin
			n_eff = ijs_pkg::CNT_W'(ijs_pkg::MAX_JOINTS);
		end else begin
			n_eff = ijs_pkg::CNT_W'(joint_count_q);
		end
	end

	assign d_k      = dist_q[k_q];
	assign out_free = !out_valid_q || !out_stall;
	assign k_last   = (ijs_pkg::CNT_W'(k_q) + 1'b1) == loaded_q;

	always_comb begin
		div_start = 1'b0;
		div_num   = span;
		div_den   = reference_speed;
		if (state_q == S_IDLE) begin
			div_start = in_acc && spd_ok;
		end else begin
			div_num   = d_k;
			div_den   = largest_q;
			div_start = (state_q == S_VEL) && !err_q && (d_k != '0) && (largest_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_count_q <= ijs_pkg::JOINT_COUNT_RST;
		end else if (cfg_wr) begin
			joint_count_q <= pwdata[ijs_pkg::CFG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dist_q[slot] <= span;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			largest_q <= '0;
			loaded_q  <= '0;
			err_q     <= 1'b0;
			k_q       <= '0;
			vel_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						loaded_q <= ijs_pkg::CNT_W'(slot) + 1'b1;
						if (spd_ok) begin
							state_q <= S_TIME;
						end else begin
							err_q   <= 1'b1;
							state_q <= S_CHK;
						end
					end
				end
				S_TIME: begin
					if (div_done) begin
						if (div_quo > largest_q) begin
							largest_q <= div_quo;
						end
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (loaded_q < n_eff) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= '0;
						state_q <= S_VEL;
					end
				end
				S_VEL: begin
					if (err_q || (d_k == '0)) begin
						vel_q   <= '0;
						state_q <= S_PUT;
					end else if (largest_q == '0) begin
						vel_q   <= ijs_pkg::SAT_VAL;
						state_q <= S_PUT;
					end else begin
						state_q <= S_VDIV;
					end
				end
				S_VDIV: begin
					if (div_done) begin
						vel_q   <= div_quo;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						if (k_last) begin
							largest_q <= '0;
							loaded_q  <= '0;
							err_q     <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_VEL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_PUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_PUT) && out_free) begin
			idx_out_q  <= ijs_pkg::OUT_IDX_W'(k_q);
			vel_out_q  <= vel_q;
			err_out_q  <= err_q;
			last_out_q <= k_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign joint_index    = idx_out_q;
	assign joint_velocity = vel_out_q;
	assign speed_error    = err_out_q;
	assign last           = last_out_q;

endmodule
